### hw/rtl/mmfb_pkg.sv
// types, codes and byte tables shared by the m-bus frame builder
`default_nettype none
package mmfb_pkg;

  // command codes
  localparam logic [1:0] OP_PING     = 2'd0;
  localparam logic [1:0] OP_REQ_UD2  = 2'd1;
  localparam logic [1:0] OP_SET_ADDR = 2'd2;
  localparam logic [1:0] OP_BAUD     = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR = 2'd1;
  localparam logic [1:0] ST_BAD_NEW  = 2'd2;
  localparam logic [1:0] ST_BAD_BAUD = 2'd3;

  // baud selection codes
  localparam logic [1:0] SEL_300  = 2'd0;
  localparam logic [1:0] SEL_2400 = 2'd1;
  localparam logic [1:0] SEL_9600 = 2'd2;
  localparam logic [1:0] SEL_BAD  = 2'd3;

  // frame kinds carried from front to back
  localparam logic [1:0] KIND_SHORT = 2'd0;
  localparam logic [1:0] KIND_SETA  = 2'd1;
  localparam logic [1:0] KIND_BAUD  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // frame bytes
  localparam logic [7:0] B_START_SHORT = 8'h10;
  localparam logic [7:0] B_START_LONG  = 8'h68;
  localparam logic [7:0] B_STOP        = 8'h16;
  localparam logic [7:0] C_SND_NKE     = 8'h40;
  localparam logic [7:0] C_REQ_UD2     = 8'h5B;
  localparam logic [7:0] C_SND_UD      = 8'h53;
  localparam logic [7:0] CI_SET_ADDR   = 8'h51;
  localparam logic [7:0] DIF_SET_ADDR  = 8'h01;
  localparam logic [7:0] VIF_SET_ADDR  = 8'h7A;
  localparam logic [7:0] L_SET_ADDR    = 8'h06;
  localparam logic [7:0] L_BAUD        = 8'h03;
  localparam logic [7:0] CI_BAUD_300   = 8'hB8;
  localparam logic [7:0] CI_BAUD_2400  = 8'hBB;
  localparam logic [7:0] CI_BAUD_9600  = 8'hBD;
  localparam logic [7:0] MAX_PRIMARY   = 8'd250;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] address;
    logic [7:0] target_addr;
    logic [1:0] baud_select;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;
  } out_t;

  // classified command handed to the byte sequencer
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [7:0] ctrl;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] cs;
  } desc_t;

  // byte number idx of the frame described by d
  function automatic out_t frame_byte_at(desc_t d, logic [3:0] idx);
    out_t o;
    o = '{frame_byte: 8'h00, last_byte: 1'b0, status: ST_OK};
    case (d.kind)
      KIND_SHORT: begin
        case (idx)
          4'd0:    o.frame_byte = B_START_SHORT;
          4'd1:    o.frame_byte = d.ctrl;
          4'd2:    o.frame_byte = d.addr;
          4'd3:    o.frame_byte = d.cs;
          default: begin
            o.frame_byte = B_STOP;
            o.last_byte  = 1'b1;
          end
        endcase
      end
      KIND_SETA: begin
        case (idx)
          4'd0, 4'd3: o.frame_byte = B_START_LONG;
          4'd1, 4'd2: o.frame_byte = L_SET_ADDR;
          4'd4:       o.frame_byte = C_SND_UD;
          4'd5:       o.frame_byte = d.addr;
          4'd6:       o.frame_byte = CI_SET_ADDR;
          4'd7:       o.frame_byte = DIF_SET_ADDR;
          4'd8:       o.frame_byte = VIF_SET_ADDR;
          4'd9:       o.frame_byte = d.data;
          4'd10:      o.frame_byte = d.cs;
          default: begin
            o.frame_byte = B_STOP;
            o.last_byte  = 1'b1;
          end
        endcase
      end
      KIND_BAUD: begin
        case (idx)
          4'd0, 4'd3: o.frame_byte = B_START_LONG;
          4'd1, 4'd2: o.frame_byte = L_BAUD;
          4'd4:       o.frame_byte = C_SND_UD;
          4'd5:       o.frame_byte = d.addr;
          4'd6:       o.frame_byte = d.data;
          4'd7:       o.frame_byte = d.cs;
          default: begin
            o.frame_byte = B_STOP;
            o.last_byte  = 1'b1;
          end
        endcase
      end
      default: begin
        o.last_byte = 1'b1;
        o.status    = d.status;
      end
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mbus_master_frame_builder.sv
// top level of the m-bus master frame builder
`default_nettype none
// Takes one command per request (ping, data request, set address, baud
// switch) and delivers its frame as a stream of bytes, one per request on
// the result side, with last_byte set on the final byte. A rejected command
// gives a single result with frame_byte 0, last_byte 1 and the status code.
// The command is classified and its checksum formed on entry, then held in a
// two-entry queue; a byte sequencer emits one byte per cycle into an output
// register unless the result side holds it back. A frame is 5 bytes (short
// frame), 12 (set address), 9 (baud switch) or 1 (rejected); a new command
// is taken each cycle while the queue has room, and frames follow each
// other with no gap.
module mbus_master_frame_builder
  import mmfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  in_t       in_data,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  desc_t front_desc;
  desc_t q_data;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  q_push;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // command classifier
  mmfb_front u_front (
    .cmd  (in_data),
    .desc (front_desc)
  );

  // descriptor queue
  mmfb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (front_desc),
    .full    (q_full),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  // byte sequencer and output register
  mmfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### hw/rtl/mmfb_front.sv
// command classifier: range checks, control and ci bytes, checksum
`default_nettype none
module mmfb_front
  import mmfb_pkg::*;
(
  input  in_t   cmd,
  output desc_t desc
);

  logic       addr_bad;
  logic [7:0] baud_ci;

  assign addr_bad = (cmd.address > MAX_PRIMARY);

  // baud code lookup
  always_comb begin
    case (cmd.baud_select)
      SEL_300:  baud_ci = CI_BAUD_300;
      SEL_2400: baud_ci = CI_BAUD_2400;
      default:  baud_ci = CI_BAUD_9600;
    endcase
  end

  // classify and precompute the checksum
  always_comb begin
    desc        = '0;
    desc.addr   = cmd.address;
    desc.status = ST_OK;
    unique case (cmd.opcode)
      OP_PING: begin
        desc.kind = KIND_SHORT;
        desc.ctrl = C_SND_NKE;
        desc.cs   = C_SND_NKE + cmd.address;
      end
      OP_REQ_UD2: begin
        desc.kind = KIND_SHORT;
        desc.ctrl = C_REQ_UD2;
        desc.cs   = C_REQ_UD2 + cmd.address;
        if (addr_bad) begin
          desc.kind   = KIND_ERR;
          desc.status = ST_BAD_ADDR;
        end
      end
      OP_SET_ADDR: begin
        desc.kind = KIND_SETA;
        desc.data = cmd.target_addr;
        desc.cs   = C_SND_UD + cmd.address + CI_SET_ADDR + DIF_SET_ADDR
                    + VIF_SET_ADDR + cmd.target_addr;
        if (addr_bad) begin
          desc.kind   = KIND_ERR;
          desc.status = ST_BAD_ADDR;
        end else if (cmd.target_addr > MAX_PRIMARY) begin
          desc.kind   = KIND_ERR;
          desc.status = ST_BAD_NEW;
        end
      end
      default: begin
        desc.kind = KIND_BAUD;
        desc.data = baud_ci;
        desc.cs   = C_SND_UD + cmd.address + baud_ci;
        if (addr_bad) begin
          desc.kind   = KIND_ERR;
          desc.status = ST_BAD_ADDR;
        end else if (cmd.baud_select == SEL_BAD) begin
          desc.kind   = KIND_ERR;
          desc.status = ST_BAD_BAUD;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/mmfb_queue.sv
// two-entry descriptor queue between classifier and sequencer
`default_nettype none
module mmfb_queue
  import mmfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  desc_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output logic  empty,
  output desc_t rd_data
);

  desc_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 2'd1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mmfb_back.sv
// byte sequencer: walks a descriptor a byte per cycle, if not stalled, to out_r
`default_nettype none
module mmfb_back
  import mmfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  desc_t q_data,
  output logic  q_pop,
  output logic  out_empty,
  input  logic  out_pop,
  output out_t  out_data
);

  desc_t      cur_r;
  logic       cur_valid_r;
  logic [3:0] idx_r;
  logic       out_valid_r;
  out_t       out_r;
  out_t       byte_nxt;
  logic       advance;
  logic       cur_done;

  assign byte_nxt  = frame_byte_at(cur_r, idx_r);
  assign advance   = cur_valid_r && (!out_valid_r || out_pop);
  assign cur_done  = advance && byte_nxt.last_byte;
  // load a new descriptor when idle or as the current frame ends
  assign q_pop     = !q_empty && (!cur_valid_r || cur_done);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // descriptor register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 4'd0;
    end else if (cur_done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else if (advance) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### verif/tb.sv
// self-checking testbench for the m-bus master frame builder
`timescale 1ns / 1ps
module tb;
  import mmfb_pkg::*;

  localparam int RANDOM_CMDS = 350;

  typedef struct {
    in_t         cmd;
    int unsigned gap;
    bit          drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_t  in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_t out_data;

  pending_t    pending_cmds[$];
  out_t        expected_bytes[$];
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  int unsigned bytes_seen = 0;
  bit          rx_calm = 1'b0;
  int          fail_count = 0;

  mbus_master_frame_builder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected byte stream for one command
  task automatic build_frame_bytes(input in_t cmd);
    logic [7:0] fr [0:11];
    logic [7:0] cs;
    logic [1:0] err;
    int         len;
    int         first;
    out_t       r;
    err   = ST_OK;
    len   = 0;
    first = 4;
    case (cmd.opcode)
      OP_PING, OP_REQ_UD2: begin
        if (cmd.opcode == OP_REQ_UD2 && cmd.address > MAX_PRIMARY) begin
          err = ST_BAD_ADDR;
        end else begin
          fr[0] = B_START_SHORT;
          fr[1] = (cmd.opcode == OP_PING) ? C_SND_NKE : C_REQ_UD2;
          fr[2] = cmd.address;
          len   = 5;
          first = 1;
        end
      end
      OP_SET_ADDR: begin
        if (cmd.address > MAX_PRIMARY) begin
          err = ST_BAD_ADDR;
        end else if (cmd.target_addr > MAX_PRIMARY) begin
          err = ST_BAD_NEW;
        end else begin
          fr[0] = B_START_LONG;
          fr[1] = L_SET_ADDR;
          fr[2] = L_SET_ADDR;
          fr[3] = B_START_LONG;
          fr[4] = C_SND_UD;
          fr[5] = cmd.address;
          fr[6] = CI_SET_ADDR;
          fr[7] = DIF_SET_ADDR;
          fr[8] = VIF_SET_ADDR;
          fr[9] = cmd.target_addr;
          len   = 12;
        end
      end
      default: begin
        if (cmd.address > MAX_PRIMARY) begin
          err = ST_BAD_ADDR;
        end else if (cmd.baud_select == SEL_BAD) begin
          err = ST_BAD_BAUD;
        end else begin
          fr[0] = B_START_LONG;
          fr[1] = L_BAUD;
          fr[2] = L_BAUD;
          fr[3] = B_START_LONG;
          fr[4] = C_SND_UD;
          fr[5] = cmd.address;
          case (cmd.baud_select)
            SEL_300:  fr[6] = CI_BAUD_300;
            SEL_2400: fr[6] = CI_BAUD_2400;
            default:  fr[6] = CI_BAUD_9600;
          endcase
          len = 9;
        end
      end
    endcase
    if (err != ST_OK) begin
      r.frame_byte = 8'h00;
      r.last_byte  = 1'b1;
      r.status     = err;
      expected_bytes.push_back(r);
    end else begin
      // checksum runs from the control byte to the last data byte
      cs = 8'h00;
      for (int k = first; k < len - 2; k++) cs = cs + fr[k];
      fr[len-2] = cs;
      fr[len-1] = B_STOP;
      for (int k = 0; k < len; k++) begin
        r.frame_byte = fr[k];
        r.last_byte  = (k == len - 1);
        r.status     = ST_OK;
        expected_bytes.push_back(r);
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    logic     accepted;
    logic     push_next;
    pending_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      accepted = in_push && !in_full;
      if (accepted) begin
        build_frame_bytes(in_data);
        if (pending_cmds.size() > 0) idle_left = pending_cmds[0].gap;
      end
      push_next = in_push && !accepted;
      if (!push_next && pending_cmds.size() > 0) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
        end else if (!(pending_cmds[0].drain_first && expected_bytes.size() > 0)) begin
          nxt = pending_cmds.pop_front();
          in_data <= nxt.cmd;
          push_next = 1'b1;
        end
      end
      in_push <= push_next;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : check_bytes
    out_t        exp_r;
    int unsigned stall;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      stall = stall_left;
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b status %0d", $time,
                   out_data.frame_byte, out_data.last_byte, out_data.status);
          fail_count++;
        end else begin
          exp_r = expected_bytes.pop_front();
          if (out_data.frame_byte !== exp_r.frame_byte) begin
            $display("%0t: frame_byte expected %02h actual %02h", $time,
                     exp_r.frame_byte, out_data.frame_byte);
            fail_count++;
          end
          if (out_data.last_byte !== exp_r.last_byte) begin
            $display("%0t: last_byte expected %0b actual %0b", $time,
                     exp_r.last_byte, out_data.last_byte);
            fail_count++;
          end
          if (out_data.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, out_data.status);
            fail_count++;
          end
        end
        // alternate between stall-free stretches and random stalls
        bytes_seen++;
        if (bytes_seen % 60 == 0) rx_calm = !rx_calm;
        stall = rx_calm ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_pop    <= 1'b0;
        stall_left = stall - 1;
      end else begin
        out_pop    <= 1'b1;
        stall_left = 0;
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] naddr, input logic [1:0] bsel,
                           input int unsigned gap, input bit drain);
    pending_t p;
    p.cmd.opcode      = op;
    p.cmd.address     = addr;
    p.cmd.target_addr = naddr;
    p.cmd.baud_select = bsel;
    p.gap             = gap;
    p.drain_first     = drain;
    pending_cmds.push_back(p);
  endtask

  function automatic logic [7:0] draw_address();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(251, 255));
      1:       return ($urandom_range(0, 1) != 0) ? MAX_PRIMARY : 8'h00;
      default: return 8'($urandom_range(0, 250));
    endcase
  endfunction

  // stimulus and end of run
  initial begin : stimulus
    bit          calm;
    logic [1:0]  op;
    logic [1:0]  bsel;
    logic [7:0]  addr;
    logic [7:0]  naddr;
    // short frames at the address limits, ping takes any address
    queue_cmd(OP_PING,     8'h00, 8'h00, SEL_300,  0, 1'b0);
    queue_cmd(OP_PING,     8'hFF, 8'hFF, SEL_BAD,  0, 1'b0);
    queue_cmd(OP_PING,     8'd251, 8'h00, SEL_300, 3, 1'b0);
    queue_cmd(OP_REQ_UD2,  8'h00, 8'hFF, SEL_BAD,  0, 1'b0);
    queue_cmd(OP_REQ_UD2,  MAX_PRIMARY, 8'h00, SEL_300, 0, 1'b0);
    queue_cmd(OP_REQ_UD2,  8'd251, 8'h00, SEL_300, 0, 1'b0);
    queue_cmd(OP_REQ_UD2,  8'hFF, 8'hFF, SEL_BAD,  5, 1'b0);
    // set address, including a bad new address and the address check first
    queue_cmd(OP_SET_ADDR, 8'h00, 8'h00, SEL_BAD,  0, 1'b0);
    queue_cmd(OP_SET_ADDR, MAX_PRIMARY, MAX_PRIMARY, SEL_300, 0, 1'b0);
    queue_cmd(OP_SET_ADDR, 8'h05, 8'd251, SEL_300, 0, 1'b0);
    queue_cmd(OP_SET_ADDR, 8'h05, 8'hFF, SEL_300,  2, 1'b0);
    queue_cmd(OP_SET_ADDR, 8'd251, 8'hFF, SEL_300, 0, 1'b0);
    queue_cmd(OP_SET_ADDR, 8'hFF, 8'hAA, SEL_300,  0, 1'b0);
    // baud switch, each rate, unsupported rate and address beating baud
    queue_cmd(OP_BAUD,     8'h00, 8'hFF, SEL_300,  0, 1'b0);
    queue_cmd(OP_BAUD,     MAX_PRIMARY, 8'h00, SEL_2400, 0, 1'b0);
    queue_cmd(OP_BAUD,     8'h55, 8'hFF, SEL_9600, 0, 1'b0);
    queue_cmd(OP_BAUD,     8'h01, 8'h00, SEL_BAD,  7, 1'b0);
    queue_cmd(OP_BAUD,     8'd251, 8'h00, SEL_BAD, 0, 1'b0);
    queue_cmd(OP_BAUD,     8'hFF, 8'h00, SEL_9600, 0, 1'b0);
    queue_cmd(OP_PING,     8'hAA, 8'h55, SEL_2400, 0, 1'b0);
    // random commands, mostly well formed, in calm and gappy stretches
    calm = 1'b0;
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      op    = 2'($urandom_range(0, 3));
      addr  = draw_address();
      naddr = draw_address();
      bsel  = ($urandom_range(0, 7) == 0) ? SEL_BAD : 2'($urandom_range(0, 2));
      queue_cmd(op, addr, naddr, bsel, calm ? 0 : $urandom_range(0, 12),
                (i == 0) || (i == RANDOM_CMDS / 2));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() > 0 || in_push || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #4000000;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
hw/rtl/mmfb_pkg.sv
hw/rtl/mmfb_front.sv
hw/rtl/mmfb_queue.sv
hw/rtl/mmfb_back.sv
hw/rtl/mbus_master_frame_builder.sv
verif/tb.sv
